// ===== design/dependency_count_task_scheduler_core_macros.svh =====
// assertion helpers shared by the scheduler core
`ifndef DEPENDENCY_COUNT_TASK_SCHEDULER_CORE_MACROS_SVH
`define DEPENDENCY_COUNT_TASK_SCHEDULER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DCTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dcts_pkg.sv =====
`timescale 1ns / 1ps
package dcts_pkg;

   // fixed field widths of the channels and the task count register
   localparam int CMD_W    = 2;
   localparam int TASK_W   = 6;
   localparam int TOTAL_W  = 7;
   // largest graph the task index field can address
   localparam int MAX_LIVE = 64;

   typedef enum logic [CMD_W-1:0] {
      OP_CLEAR,
      OP_EDGE,
      OP_START,
      OP_DONE
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EDGE_CHK,
      ST_ACCUM,
      ST_CNT_CHK,
      ST_SWEEP,
      ST_DONE_CHK,
      ST_SCAN,
      ST_FINISH,
      ST_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic clear_all;
      logic read_t;
      logic write_edge;
      logic accum_init;
      logic accum_step;
      logic start_run;
      logic sweep_step;
      logic done_accept;
      logic scan_step;
      logic push_single;
      logic push_final;
      logic reply_err;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   running;
      logic   t_ok;
      logic   d_ok;
      logic   self_edge;
      logic   edge_dup;
      logic   accum_done;
      logic   any_entry;
      logic   sweep_done;
      logic   done_bad;
      logic   scan_done;
      logic   out_free;
   } dp_status_type;

endpackage

// ===== design/dcts_intf.sv =====
`timescale 1ns / 1ps
// command channel
interface dcts_req_intf import dcts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TASK_W-1:0] task_index;
   logic [TASK_W-1:0] dependant_index;

   modport source (output valid, cmd, task_index, dependant_index, input ready);
   modport sink   (input valid, cmd, task_index, dependant_index, output ready);
endinterface

// result channel
interface dcts_rsp_intf import dcts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              has_task;
   logic [TASK_W-1:0] ready_task;
   logic              last;
   logic              run_done;
   logic              error;

   modport source (output valid, has_task, ready_task, last, run_done, error, input ready);
   modport sink   (input valid, has_task, ready_task, last, run_done, error, output ready);
endinterface

// ===== design/dependency_count_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// Dependency-counting task scheduler. Takes one command item at a time on req_ch and answers
// with one or more result items on rsp_ch, the final one marked last. Clear and add edge each
// give a single result. Start reads the dependant matrix one row per cycle through its single
// read port to count every task's dependencies, then walks the tasks one per cycle, stalling
// while a held result cannot leave on rsp_ch, to load the counts and emit the entry tasks.
// Task finished walks the tasks one per cycle through the remaining-count memory, also
// stalling while a held result cannot leave, to count down the finished task's dependants.
// A new command is taken once the previous one has queued its final result. The graph clears
// at once on reset or on a clear command (row valid flags), so there is no clearing pass.
// task_total is to be written through csr_we and csr_wdata only while no command is in flight;
// the block itself does not enforce that, but a write during a run is ignored.
`include "dependency_count_task_scheduler_core_macros.svh"
module dependency_count_task_scheduler_core import dcts_pkg::*; #(
   parameter int MAX_TASKS = 64
) (
   input  logic               clock,
   input  logic               reset,
   dcts_req_intf.sink         req_ch,
   dcts_rsp_intf.source       rsp_ch,
   input  logic               csr_we,
   input  logic [TOTAL_W-1:0] csr_wdata
);

   ctrl_cmd_type  ctl;
   dp_status_type sts;

   // shorthand terms for the checks at the end
   logic req_take;
   logic rsp_err;
   logic err_shape;
   logic rsp_mid;
   logic mid_shape;

   // sequencer
   dcts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // graph storage, counters and result register
   dcts_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .req_cmd             (req_ch.cmd),
      .req_task_index      (req_ch.task_index),
      .req_dependant_index (req_ch.dependant_index),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_has_task        (rsp_ch.has_task),
      .rsp_ready_task      (rsp_ch.ready_task),
      .rsp_last            (rsp_ch.last),
      .rsp_run_done        (rsp_ch.run_done),
      .rsp_error           (rsp_ch.error)
   );

   assign req_take  = req_ch.valid && req_ch.ready;
   assign rsp_err   = rsp_ch.valid && rsp_ch.error;
   assign err_shape = rsp_ch.last && !rsp_ch.has_task;
   assign rsp_mid   = rsp_ch.valid && !rsp_ch.last;
   assign mid_shape = rsp_ch.has_task && !rsp_ch.run_done && !rsp_ch.error;

   // one command in flight at a time
   `DCTS_ASSERT_NEXT(a_one_item, clock, reset, req_take, !req_ch.ready, "command taken while busy")
   // a rejected command answers with one empty final result
   `DCTS_ASSERT_NOW(a_error_single, clock, reset, rsp_err, err_shape, "error result not single")
   // only the final result may be empty or end the run
   `DCTS_ASSERT_NOW(a_mid_has_task, clock, reset, rsp_mid, mid_shape, "mid result without task")

endmodule

// ===== design/dcts_datapath.sv =====
`timescale 1ns / 1ps
module dcts_datapath import dcts_pkg::*; #(
   parameter int MAX_TASKS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       ctl,
   output dp_status_type      sts,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [TASK_W-1:0]  req_task_index,
   input  logic [TASK_W-1:0]  req_dependant_index,
   input  logic               csr_we,
   input  logic [TOTAL_W-1:0] csr_wdata,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_has_task,
   output logic [TASK_W-1:0]  rsp_ready_task,
   output logic               rsp_last,
   output logic               rsp_run_done,
   output logic               rsp_error
);

   localparam int DEPTH = (MAX_TASKS < MAX_LIVE) ? MAX_TASKS : MAX_LIVE;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // latched item
   op_type             cmd_ff;
   logic [TASK_W-1:0]  t_ff;
   logic [TASK_W-1:0]  d_ff;

   // control state
   logic [TOTAL_W-1:0] task_total_ff;
   logic               running_ff;
   logic [CNT_W-1:0]   tasks_left_ff;
   logic [DEPTH-1:0]   finished_ff;
   logic [DEPTH-1:0]   row_valid_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic               acc_vld_ff;
   logic               b_vld_ff;
   logic               pend_vld_ff;
   logic               rsp_valid_ff;

   // datapath registers
   logic [CNT_W-1:0]   cnt_ff [DEPTH];
   logic [DEPTH-1:0]   row_ff;
   logic [IDX_W-1:0]   b_idx_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic               has_ff;
   logic [TASK_W-1:0]  task_ff;
   logic               last_ff;
   logic               done_ff;
   logic               err_ff;

   // memories and their read registers
   logic [DEPTH-1:0]   mat_mem [DEPTH];
   logic [CNT_W-1:0]   dt_mem  [DEPTH];
   logic [CNT_W-1:0]   rem_mem [DEPTH];
   logic [DEPTH-1:0]   mat_rd_ff;
   logic               mat_vld_ff;
   logic [CNT_W-1:0]   dt_rd_ff;
   logic [CNT_W-1:0]   rem_rd_ff;

   logic [CNT_W-1:0]   live_n;
   logic [IDX_W-1:0]   t_idx;
   logic [IDX_W-1:0]   d_idx;
   logic [IDX_W-1:0]   ptr_idx;
   logic               ptr_lt_n;
   logic [DEPTH-1:0]   lane_mask;
   logic [DEPTH-1:0]   lane_zero;
   logic [DEPTH-1:0]   row_data;
   logic [DEPTH-1:0]   one_hot;
   logic               out_free;
   logic               sweep_emit;
   logic               sweep_go;
   logic               scan_hit;
   logic               scan_go;
   logic               scan_dec;
   logic               scan_rd;
   logic               emit_now;
   logic               new_pend;
   logic [IDX_W-1:0]   new_pend_idx;
   logic               load_out;
   logic               mat_rd_en;
   logic [IDX_W-1:0]   mat_raddr;
   logic               rem_rd_en;
   logic [IDX_W-1:0]   rem_raddr;
   logic               rem_we;
   logic [IDX_W-1:0]   rem_waddr;
   logic [CNT_W-1:0]   rem_wdata;

   // task count clamped between one and the storage depth
   always_comb begin
      if (task_total_ff == '0) begin
         live_n = CNT_W'(1);
      end else if (task_total_ff > TOTAL_W'(DEPTH)) begin
         live_n = CNT_W'(DEPTH);
      end else begin
         live_n = CNT_W'(task_total_ff);
      end
   end

   assign t_idx    = t_ff[IDX_W-1:0];
   assign d_idx    = d_ff[IDX_W-1:0];
   assign ptr_idx  = ptr_ff[IDX_W-1:0];
   assign ptr_lt_n = ptr_ff < live_n;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // per-lane masks
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         lane_mask[j] = CNT_W'(j) < live_n;
         lane_zero[j] = cnt_ff[j] == '0;
      end
   end

   // row read back, empty when the row was never written since clear
   assign row_data = mat_vld_ff ? mat_rd_ff : '0;

   always_comb begin
      one_hot        = '0;
      one_hot[d_idx] = 1'b1;
   end

   // sweep and scan step control, stalling when a held result cannot leave
   assign sweep_emit = cnt_ff[0] == '0;
   assign sweep_go   = ctl.sweep_step && ptr_lt_n &&
                       !(sweep_emit && pend_vld_ff && !out_free);
   assign scan_hit   = b_vld_ff && (rem_rd_ff == CNT_W'(1));
   assign scan_go    = ctl.scan_step && !(scan_hit && pend_vld_ff && !out_free);
   assign scan_dec   = scan_go && b_vld_ff && (rem_rd_ff != '0);
   assign scan_rd    = scan_go && ptr_lt_n;
   assign new_pend   = (sweep_go && sweep_emit) || (scan_go && scan_hit);
   assign new_pend_idx = sweep_go ? ptr_idx : b_idx_ff;
   assign emit_now   = new_pend && pend_vld_ff;
   assign load_out   = ctl.push_single || ctl.push_final || emit_now;

   // memory port selection
   assign mat_rd_en = ctl.read_t || (ctl.accum_step && ptr_lt_n);
   assign mat_raddr = ctl.read_t ? t_idx : ptr_idx;
   assign rem_rd_en = ctl.read_t || scan_rd;
   assign rem_raddr = ctl.read_t ? t_idx : ptr_idx;
   assign rem_we    = sweep_go || ctl.done_accept || scan_dec;

   always_comb begin
      if (sweep_go) begin
         rem_waddr = ptr_idx;
         rem_wdata = cnt_ff[0];
      end else if (ctl.done_accept) begin
         rem_waddr = t_idx;
         rem_wdata = dt_rd_ff;
      end else begin
         rem_waddr = b_idx_ff;
         rem_wdata = rem_rd_ff - CNT_W'(1);
      end
   end

   // dependant matrix
   always_ff @(posedge clock) begin
      if (ctl.write_edge) begin
         mat_mem[t_idx] <= row_data | one_hot;
      end
      if (mat_rd_en) begin
         mat_rd_ff  <= mat_mem[mat_raddr];
         mat_vld_ff <= row_valid_ff[mat_raddr];
      end
   end

   // dependency totals
   always_ff @(posedge clock) begin
      if (sweep_go) begin
         dt_mem[ptr_idx] <= cnt_ff[0];
      end
      if (ctl.read_t) begin
         dt_rd_ff <= dt_mem[t_idx];
      end
   end

   // remaining counts
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      if (rem_rd_en) begin
         rem_rd_ff <= rem_mem[rem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_total_ff <= TOTAL_W'(1);
         running_ff    <= 1'b0;
         tasks_left_ff <= '0;
         finished_ff   <= '0;
         row_valid_ff  <= '0;
         ptr_ff        <= '0;
         acc_vld_ff    <= 1'b0;
         b_vld_ff      <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && !running_ff) begin
            task_total_ff <= csr_wdata;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.clear_all) begin
            row_valid_ff  <= '0;
            finished_ff   <= '0;
            tasks_left_ff <= '0;
            running_ff    <= 1'b0;
         end else if (ctl.write_edge) begin
            row_valid_ff[t_idx] <= 1'b1;
         end else if (ctl.accum_init) begin
            ptr_ff     <= '0;
            acc_vld_ff <= 1'b0;
         end else if (ctl.accum_step) begin
            acc_vld_ff <= ptr_lt_n;
            if (ptr_lt_n) begin
               ptr_ff <= ptr_ff + CNT_W'(1);
            end
         end else if (ctl.start_run) begin
            running_ff    <= 1'b1;
            tasks_left_ff <= live_n;
            finished_ff   <= '0;
            ptr_ff        <= '0;
            pend_vld_ff   <= 1'b0;
         end else if (ctl.done_accept) begin
            finished_ff[t_idx] <= 1'b1;
            if (tasks_left_ff != '0) begin
               tasks_left_ff <= tasks_left_ff - CNT_W'(1);
            end
            ptr_ff      <= '0;
            b_vld_ff    <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else if (ctl.push_final) begin
            pend_vld_ff <= 1'b0;
            if (tasks_left_ff == '0) begin
               running_ff <= 1'b0;
            end
         end else begin
            if (sweep_go) begin
               ptr_ff <= ptr_ff + CNT_W'(1);
            end
            if (scan_go) begin
               b_vld_ff <= ptr_lt_n && row_ff[0];
               if (ptr_lt_n) begin
                  ptr_ff <= ptr_ff + CNT_W'(1);
               end
            end
            if (new_pend) begin
               pend_vld_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= op_type'(req_cmd);
         t_ff   <= req_task_index;
         d_ff   <= req_dependant_index;
      end
      // column count lanes: accumulate rows, then shift out toward lane 0
      if (ctl.accum_init) begin
         for (int j = 0; j < DEPTH; j++) begin
            cnt_ff[j] <= '0;
         end
      end else if (ctl.accum_step && acc_vld_ff) begin
         for (int j = 0; j < DEPTH; j++) begin
            cnt_ff[j] <= cnt_ff[j] + CNT_W'(row_data[j] & lane_mask[j]);
         end
      end else if (sweep_go) begin
         for (int j = 0; j < DEPTH - 1; j++) begin
            cnt_ff[j] <= cnt_ff[j + 1];
         end
         cnt_ff[DEPTH-1] <= '0;
      end
      // dependants of the finished task still waiting
      if (ctl.done_accept) begin
         row_ff <= row_data & lane_mask & ~finished_ff;
      end else if (scan_rd) begin
         row_ff   <= row_ff >> 1;
         b_idx_ff <= ptr_idx;
      end
      if (new_pend) begin
         pend_idx_ff <= new_pend_idx;
      end
      // result register
      if (ctl.push_single) begin
         has_ff  <= 1'b0;
         task_ff <= '0;
         last_ff <= 1'b1;
         done_ff <= 1'b0;
         err_ff  <= ctl.reply_err;
      end else if (ctl.push_final) begin
         has_ff  <= pend_vld_ff;
         task_ff <= pend_vld_ff ? TASK_W'(pend_idx_ff) : '0;
         last_ff <= 1'b1;
         done_ff <= tasks_left_ff == '0;
         err_ff  <= 1'b0;
      end else if (emit_now) begin
         has_ff  <= 1'b1;
         task_ff <= TASK_W'(pend_idx_ff);
         last_ff <= 1'b0;
         done_ff <= 1'b0;
         err_ff  <= 1'b0;
      end
   end

   // status to the controller
   always_comb begin
      sts.op         = cmd_ff;
      sts.running    = running_ff;
      sts.t_ok       = TOTAL_W'(t_ff) < TOTAL_W'(live_n);
      sts.d_ok       = TOTAL_W'(d_ff) < TOTAL_W'(live_n);
      sts.self_edge  = t_ff == d_ff;
      sts.edge_dup   = mat_vld_ff && mat_rd_ff[d_idx];
      sts.accum_done = !ptr_lt_n && !acc_vld_ff;
      sts.any_entry  = |(lane_zero & lane_mask);
      sts.sweep_done = !ptr_lt_n;
      sts.done_bad   = (rem_rd_ff != '0) || finished_ff[t_idx];
      sts.scan_done  = !ptr_lt_n && !b_vld_ff;
      sts.out_free   = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_task   = has_ff;
   assign rsp_ready_task = task_ff;
   assign rsp_last       = last_ff;
   assign rsp_run_done   = done_ff;
   assign rsp_error      = err_ff;

endmodule

// ===== design/dcts_ctrl.sv =====
`timescale 1ns / 1ps
module dcts_ctrl import dcts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  ctl
);

   state_type state_ff;
   state_type state_in;
   logic      err_ff;
   logic      err_in;
   logic      edge_bad;
   logic      done_early_bad;

   // checks that need no memory read
   assign edge_bad       = sts.running || !sts.t_ok || !sts.d_ok || sts.self_edge;
   assign done_early_bad = !sts.running || !sts.t_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               OP_CLEAR: begin
                  state_in = ST_REPLY;
                  err_in   = 1'b0;
               end
               OP_EDGE: begin
                  if (edge_bad) begin
                     state_in = ST_REPLY;
                     err_in   = 1'b1;
                  end else begin
                     state_in = ST_EDGE_CHK;
                  end
               end
               OP_START: begin
                  if (sts.running) begin
                     state_in = ST_REPLY;
                     err_in   = 1'b1;
                  end else begin
                     state_in = ST_ACCUM;
                  end
               end
               OP_DONE: begin
                  if (done_early_bad) begin
                     state_in = ST_REPLY;
                     err_in   = 1'b1;
                  end else begin
                     state_in = ST_DONE_CHK;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EDGE_CHK: begin
            state_in = ST_REPLY;
            err_in   = sts.edge_dup;
         end
         ST_ACCUM: begin
            if (sts.accum_done) begin
               state_in = ST_CNT_CHK;
            end
         end
         ST_CNT_CHK: begin
            if (sts.any_entry) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_REPLY;
               err_in   = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (sts.sweep_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_DONE_CHK: begin
            if (sts.done_bad) begin
               state_in = ST_REPLY;
               err_in   = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         ST_DECODE: begin
            case (sts.op)
               OP_CLEAR: ctl.clear_all  = 1'b1;
               OP_EDGE:  ctl.read_t     = !edge_bad;
               OP_START: ctl.accum_init = !sts.running;
               OP_DONE:  ctl.read_t     = !done_early_bad;
               default:  ctl.clear_all  = 1'b0;
            endcase
         end
         ST_EDGE_CHK: begin
            ctl.write_edge = !sts.edge_dup;
         end
         ST_ACCUM: begin
            ctl.accum_step = 1'b1;
         end
         ST_CNT_CHK: begin
            ctl.start_run = sts.any_entry;
         end
         ST_SWEEP: begin
            ctl.sweep_step = 1'b1;
         end
         ST_DONE_CHK: begin
            ctl.done_accept = !sts.done_bad;
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
         end
         ST_FINISH: begin
            ctl.push_final = sts.out_free;
         end
         ST_REPLY: begin
            ctl.push_single = sts.out_free;
            ctl.reply_err   = err_ff;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== dv/dependency_count_task_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
module dependency_count_task_scheduler_core_tb;
   import dcts_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 10;
   // longest quiet stretch: a full 64-task start plus the end-of-run wait, taken many times
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE       = 12;
   localparam int TAIL_CYCLES  = 150;
   // random items after the directed ones, at least 156 in all
   localparam int RANDOM_ITEMS = 130;
   localparam int DONE_CAP     = 16;

   typedef struct packed {
      logic              has_task;
      logic [TASK_W-1:0] ready_task;
      logic              last;
      logic              run_done;
      logic              error;
   } sched_rsp_t;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [TOTAL_W-1:0] csr_wdata;

   dcts_req_intf req_if ();
   dcts_rsp_intf rsp_if ();

   dependency_count_task_scheduler_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the scheduler state
   logic [MAX_LIVE-1:0] dependants [MAX_LIVE];
   logic [TOTAL_W-1:0]  dep_total [MAX_LIVE];
   logic [TOTAL_W-1:0]  waits_left [MAX_LIVE];
   logic [MAX_LIVE-1:0] finished_set;
   int                  tasks_pending;
   logic                run_active;
   logic [TOTAL_W-1:0]  task_total_q;

   sched_rsp_t expected_rsp [$];

   int          mismatches;
   int          items_sent;
   int          results_seen;
   int          runs_finished;
   int          rejects_seen;
   int          burst_left;
   int          idle_cycles;
   int          pattern_age;
   logic [15:0] stall_pattern;

   always #CLK_HALF clock = ~clock;

   function automatic int live_tasks();
      int n;
      n = int'(task_total_q);
      if (n < 1) n = 1;
      if (n > MAX_LIVE) n = MAX_LIVE;
      return n;
   endfunction

   function automatic void clear_graph();
      for (int i = 0; i < MAX_LIVE; i++) begin
         dependants[i] = '0;
         dep_total[i]  = '0;
         waits_left[i] = '0;
      end
      finished_set  = '0;
      tasks_pending = 0;
      run_active    = 1'b0;
   endfunction

   // work out the ready tasks one command item releases and queue them
   function automatic void predict_ready_tasks(op_type op, logic [TASK_W-1:0] t,
                                               logic [TASK_W-1:0] d);
      sched_rsp_t batch [$];
      sched_rsp_t r;
      int         n;
      int         c;
      logic       any_entry;
      logic       reject;
      n      = live_tasks();
      reject = 1'b0;
      r      = '0;
      case (op)
         OP_CLEAR: clear_graph();
         OP_EDGE: begin
            if (run_active || t >= n || d >= n || t == d || dependants[t][d]) reject = 1'b1;
            else dependants[t][d] = 1'b1;
         end
         OP_START: begin
            if (run_active) begin
               reject = 1'b1;
            end else begin
               // count each task's dependencies among the live tasks only
               any_entry = 1'b0;
               for (int i = 0; i < n; i++) begin
                  c = 0;
                  for (int s = 0; s < n; s++) c += int'(dependants[s][i]);
                  dep_total[i] = TOTAL_W'(c);
                  if (c == 0) any_entry = 1'b1;
               end
               if (!any_entry) begin
                  reject = 1'b1;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     waits_left[i]   = dep_total[i];
                     finished_set[i] = 1'b0;
                     if (dep_total[i] == 0) begin
                        r.has_task   = 1'b1;
                        r.ready_task = TASK_W'(i);
                        batch.push_back(r);
                     end
                  end
                  tasks_pending = n;
                  run_active    = 1'b1;
               end
            end
         end
         OP_DONE: begin
            if (!run_active || t >= n || waits_left[t] != 0 || finished_set[t]) begin
               reject = 1'b1;
            end else begin
               finished_set[t] = 1'b1;
               waits_left[t]   = dep_total[t];
               if (tasks_pending > 0) tasks_pending--;
               // release dependants in index order
               for (int i = 0; i < n; i++) begin
                  if (!dependants[t][i] || finished_set[i] || waits_left[i] == 0) continue;
                  waits_left[i] = waits_left[i] - TOTAL_W'(1);
                  if (waits_left[i] == 0) begin
                     r.has_task   = 1'b1;
                     r.ready_task = TASK_W'(i);
                     batch.push_back(r);
                  end
               end
               if (batch.size() == 0) batch.push_back('0);
               if (tasks_pending == 0) begin
                  run_active = 1'b0;
                  batch[batch.size() - 1].run_done = 1'b1;
               end
            end
         end
      endcase
      // single bare item for clear, edge, and rejected commands
      if (batch.size() == 0) begin
         r       = '0;
         r.error = reject;
         batch.push_back(r);
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_rsp.push_back(batch[k]);
   endfunction

   // drive one command item, bursts with random gaps between them
   task automatic send_command(op_type op, logic [TASK_W-1:0] t, logic [TASK_W-1:0] d);
      int gap;
      @(negedge clock);
      req_if.valid           <= 1'b1;
      req_if.cmd             <= op;
      req_if.task_index      <= t;
      req_if.dependant_index <= d;
      do @(posedge clock); while (!req_if.ready);
      predict_ready_tasks(op, t, d);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 8);
         gap        = $urandom_range(1, 5);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold off until every expected result is in and the block has settled
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_task_total(logic [TOTAL_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      // the block keeps its count while a run is in progress
      if (!run_active) task_total_q = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [TOTAL_W-1:0] random_total();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return TOTAL_W'($urandom_range(64, 127));
         2:       return TOTAL_W'($urandom_range(9, 63));
         default: return TOTAL_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic void check_field(string name, logic [TASK_W-1:0] want,
                                       logic [TASK_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      sched_rsp_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (rsp_if.error) rejects_seen++;
         if (rsp_if.run_done) runs_finished++;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result item: has_task %0b ready_task %0d", rsp_if.has_task,
                   rsp_if.ready_task);
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("has_task", TASK_W'(want.has_task), TASK_W'(rsp_if.has_task));
            check_field("ready_task", want.ready_task, rsp_if.ready_task);
            check_field("last", TASK_W'(want.last), TASK_W'(rsp_if.last));
            check_field("run_done", TASK_W'(want.run_done), TASK_W'(rsp_if.run_done));
            check_field("error", TASK_W'(want.error), TASK_W'(rsp_if.error));
         end
      end
   end

   // receiver stalls follow a rotating pattern, refreshed now and then
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
         pattern_age   = 200;
      end
      pattern_age--;
      rsp_if.ready  <= stall_pattern[0];
      stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results pending", IDLE_LIMIT,
                  expected_rsp.size());
         $display("FAILURE");
         $finish;
      end
   end

   // single task after reset, done while idle, start while running
   task automatic check_idle_commands();
      send_command(OP_DONE, 6'd0, 6'd0);
      send_command(OP_START, 6'd0, 6'd0);
      send_command(OP_START, 6'd0, 6'd0);
      send_command(OP_DONE, 6'd0, 6'd0);
   endtask

   // edge rules and done rules on a three task chain
   task automatic check_edge_rules();
      write_task_total(7'd3);
      send_command(OP_EDGE, 6'd0, 6'd1);
      send_command(OP_EDGE, 6'd0, 6'd1);
      send_command(OP_EDGE, 6'd2, 6'd2);
      send_command(OP_EDGE, 6'd3, 6'd1);
      send_command(OP_EDGE, 6'd1, 6'd2);
      send_command(OP_START, 6'd0, 6'd0);
      send_command(OP_EDGE, 6'd2, 6'd0);
      send_command(OP_DONE, 6'd1, 6'd0);
      send_command(OP_DONE, 6'd5, 6'd0);
      send_command(OP_DONE, 6'd0, 6'd0);
      send_command(OP_DONE, 6'd0, 6'd0);
      send_command(OP_DONE, 6'd1, 6'd0);
      // register write during the run must not take
      write_task_total(7'd1);
      send_command(OP_DONE, 6'd2, 6'd0);
   endtask

   // closed loop gives no entry task; a smaller count drops the edge that closed it
   task automatic check_count_limits();
      send_command(OP_EDGE, 6'd2, 6'd0);
      send_command(OP_START, 6'd0, 6'd0);
      write_task_total(7'd2);
      send_command(OP_START, 6'd0, 6'd0);
      send_command(OP_CLEAR, 6'd0, 6'd0);
   endtask

   // count clamped at both ends, top task indices, full fan-out start
   task automatic check_wide_graph();
      write_task_total(7'd127);
      send_command(OP_EDGE, 6'd63, 6'd62);
      send_command(OP_START, 6'd63, 6'd63);
      send_command(OP_DONE, 6'd63, 6'd0);
      send_command(OP_CLEAR, 6'd63, 6'd63);
      write_task_total(7'd0);
      send_command(OP_START, 6'd0, 6'd0);
   endtask

   // random graphs: build, start, finish ready tasks, with noise mixed in
   task automatic run_random_graphs();
      int                n;
      int                pick;
      int                dones;
      int                first_item;
      int                ready_list [$];
      logic [TASK_W-1:0] t;
      logic [TASK_W-1:0] d;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) write_task_total(random_total());
         send_command(OP_CLEAR, TASK_W'($urandom), TASK_W'($urandom));
         n = live_tasks();
         repeat ($urandom_range(0, (n < 6) ? 2 * n : 12)) begin
            pick = $urandom_range(0, 19);
            if (pick < 15 && n > 1) begin
               // forward edges keep the graph acyclic
               t = TASK_W'($urandom_range(0, n - 2));
               d = TASK_W'($urandom_range(t + 1, n - 1));
            end else if (pick < 17) begin
               t = TASK_W'($urandom_range(0, n - 1));
               d = TASK_W'($urandom_range(0, n - 1));
            end else begin
               t = TASK_W'($urandom);
               d = TASK_W'($urandom);
            end
            send_command(OP_EDGE, t, d);
         end
         send_command(OP_START, TASK_W'($urandom), TASK_W'($urandom));
         dones = 0;
         while (run_active && dones < DONE_CAP) begin
            ready_list.delete();
            for (int i = 0; i < n; i++)
               if (waits_left[i] == 0 && !finished_set[i]) ready_list.push_back(i);
            // only tasks on a loop are left
            if (ready_list.size() == 0) break;
            case ($urandom_range(0, 19))
               0: send_command(OP_DONE, TASK_W'($urandom), TASK_W'($urandom));
               1: send_command(OP_EDGE, TASK_W'($urandom), TASK_W'($urandom));
               2: send_command(OP_START, TASK_W'($urandom), TASK_W'($urandom));
               3: send_command(OP_CLEAR, TASK_W'($urandom), TASK_W'($urandom));
               default: begin
                  send_command(OP_DONE,
                               TASK_W'(ready_list[$urandom_range(0, ready_list.size() - 1)]),
                               TASK_W'($urandom));
                  dones++;
               end
            endcase
         end
      end
   endtask

   initial begin
      int directed_items;
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      req_if.valid           = 1'b0;
      req_if.cmd             = OP_CLEAR;
      req_if.task_index      = '0;
      req_if.dependant_index = '0;
      rsp_if.ready           = 1'b1;
      stall_pattern          = 16'hffff;
      pattern_age            = 0;
      idle_cycles            = 0;
      mismatches             = 0;
      items_sent             = 0;
      results_seen           = 0;
      runs_finished          = 0;
      rejects_seen           = 0;
      burst_left             = 0;
      task_total_q           = 7'd1;
      clear_graph();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_idle_commands();
      check_edge_rules();
      check_count_limits();
      check_wide_graph();
      directed_items = items_sent;
      run_random_graphs();

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d command items (%0d directed, rest random graphs), checked %0d results",
               items_sent, directed_items, results_seen);
      $display("runs seen to completion: %0d, commands rejected: %0d", runs_finished,
               rejects_seen);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
